@@ hdl/sorted_timer_queue_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication under the block's clock and reset.
`define STQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_timer_queue check failed");

// Next-cycle implication under the block's clock and reset.
`define STQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_timer_queue check failed");

`endif

@@ hdl/stq_pkg.sv @@
package stq_pkg;

   // Default table depth.
   localparam int TIMER_SLOTS_DEF = 16;

   // Field widths.
   localparam int NOW_W   = 48;
   localparam int DLY_W   = 32;
   localparam int TASK_W  = 8;
   localparam int EXP_W   = 49;
   localparam int REQ_DW  = 120;
   localparam int RSP_DW  = 64;

   // Timeout reported for an empty table after reset.
   localparam logic [DLY_W-1:0] IDLE_TIMEOUT_RST = 32'd1000;

   // Request types.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_EXPIRE = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_INFO  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic add;
      logic pop_head;
      logic set_none;
      logic reins;
      logic calc;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_due;
      logic fire_empty;
      logic reins_last;
      logic out_last;
   } stat_type;

endpackage

@@ hdl/sorted_timer_queue.sv @@
// Sorted timer queue: holds up to TIMER_SLOTS timers ordered by expiration.
// Requests arrive on the req_ stream: tuser carries the request type (add,
// expire, query) and tdata the time, delay, interval and task. Results leave
// on the rsp_ stream; tuser carries the result kind, tlast marks the final
// item of a request. The idle timeout register is written through csr_we.
// One request is handled at a time; req_tready is low until the cycle after
// its last result item has been taken. An add inserts the timer and then
// computes the nearest delay before its result item; a query only computes
// the nearest delay. An expire removes the due timers from the head of the
// table one at a time until the head is no longer due, walks the fired
// timers to put the periodic ones back (one sorted insert per cycle),
// computes the nearest delay, then shows one result item per fired timer,
// one per cycle while the receiver takes them (one item when nothing
// fired). The sorted insert and the head removal bound the rate.
// A stalled receiver holds the current result item in place.
// Reset empties the table, restores the idle timeout to 1000 and leaves
// req_tready high, so a request can be taken right after reset.
module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // now_ms[47:0], delay_ms[79:48], interval_ms[111:80], task_id[119:112]
   input  logic [REQ_DW-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // fired_task[7:0], accepted[8], became_earliest[9],
   // nearest_delay_ms[58:10], zero[63:59]
   output logic [RSP_DW-1:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic [DLY_W-1:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign rsp_tlast = stat.out_last;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_user  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stq_datapath #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_user  (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_user  (rsp_tuser),
      .rsp_data  (rsp_tdata)
   );

endmodule

@@ hdl/stq_datapath.sv @@
module stq_datapath
   import stq_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        req_user,
   input  logic [REQ_DW-1:0] req_data,
   input  logic              csr_we,
   input  logic [DLY_W-1:0]  csr_wdata,
   output logic [1:0]        rsp_user,
   output logic [RSP_DW-1:0] rsp_data
);

   localparam int CW = $clog2(TIMER_SLOTS + 1);

   // Request fields, results and configuration.
   logic [NOW_W-1:0]  now_ff;
   logic [DLY_W-1:0]  delay_ff;
   logic [DLY_W-1:0]  ival_ff;
   logic [TASK_W-1:0] tid_ff;
   logic [1:0]        kind_ff;
   logic              acc_ff;
   logic              early_ff;
   logic [EXP_W-1:0]  near_ff;
   logic [DLY_W-1:0]  idle_ff;
   logic [CW-1:0]     pend_ff, pend_in;
   logic [CW-1:0]     fcnt_ff, fcnt_in;
   logic [CW-1:0]     rcnt_ff;

   // Sorted timer table; entries below pend_ff are in use.
   logic [EXP_W-1:0]  exp_ff [TIMER_SLOTS];
   logic [DLY_W-1:0]  per_ff [TIMER_SLOTS];
   logic [TASK_W-1:0] tsk_ff [TIMER_SLOTS];
   logic [EXP_W-1:0]  exp_in [TIMER_SLOTS];
   logic [DLY_W-1:0]  per_in [TIMER_SLOTS];
   logic [TASK_W-1:0] tsk_in [TIMER_SLOTS];

   // Queue of fired timers, in firing order.
   logic [DLY_W-1:0]  qper_ff [TIMER_SLOTS];
   logic [TASK_W-1:0] qtsk_ff [TIMER_SLOTS];
   logic [DLY_W-1:0]  qper_in [TIMER_SLOTS];
   logic [TASK_W-1:0] qtsk_in [TIMER_SLOTS];

   // Neighbor views for shifting.
   logic [TIMER_SLOTS-1:0] gt;
   logic [TIMER_SLOTS-1:0] gt_prev;
   logic [EXP_W-1:0]  exp_dn [TIMER_SLOTS];
   logic [DLY_W-1:0]  per_dn [TIMER_SLOTS];
   logic [TASK_W-1:0] tsk_dn [TIMER_SLOTS];
   logic [EXP_W-1:0]  exp_up [TIMER_SLOTS];
   logic [DLY_W-1:0]  per_up [TIMER_SLOTS];
   logic [TASK_W-1:0] tsk_up [TIMER_SLOTS];
   logic [DLY_W-1:0]  qper_up [TIMER_SLOTS];
   logic [TASK_W-1:0] qtsk_up [TIMER_SLOTS];

   logic [EXP_W-1:0]  ins_exp;
   logic [DLY_W-1:0]  ins_dly;
   logic [DLY_W-1:0]  ins_per;
   logic [TASK_W-1:0] ins_tid;
   logic              ins_en;
   logic              full;
   logic              head_due;
   logic              fired_kind;

   assign full       = (pend_ff == CW'(TIMER_SLOTS));
   assign head_due   = (pend_ff != '0) && (exp_ff[0] <= {1'b0, now_ff});
   assign fired_kind = (kind_ff == KIND_FIRED);

   // Select the timer to insert: a new add or the head of the fired queue.
   always_comb begin
      if (cmd.reins) begin
         ins_dly = qper_ff[0];
         ins_per = qper_ff[0];
         ins_tid = qtsk_ff[0];
         ins_en  = (qper_ff[0] != '0);
      end else begin
         ins_dly = (delay_ff == '0) ? DLY_W'(1) : delay_ff;
         ins_per = ival_ff;
         ins_tid = tid_ff;
         ins_en  = cmd.add && !full;
      end
      ins_exp = {1'b0, now_ff} + EXP_W'(ins_dly);
   end

   // Per-entry compare and neighbor values.
   always_comb begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         gt[i] = (CW'(i) < pend_ff) && (exp_ff[i] > ins_exp);
      end
      gt_prev[0] = 1'b0;
      exp_dn[0]  = exp_ff[0];
      per_dn[0]  = per_ff[0];
      tsk_dn[0]  = tsk_ff[0];
      for (int i = 1; i < TIMER_SLOTS; i++) begin
         gt_prev[i] = gt[i-1];
         exp_dn[i]  = exp_ff[i-1];
         per_dn[i]  = per_ff[i-1];
         tsk_dn[i]  = tsk_ff[i-1];
      end
      exp_up[TIMER_SLOTS-1]  = exp_ff[TIMER_SLOTS-1];
      per_up[TIMER_SLOTS-1]  = per_ff[TIMER_SLOTS-1];
      tsk_up[TIMER_SLOTS-1]  = tsk_ff[TIMER_SLOTS-1];
      qper_up[TIMER_SLOTS-1] = qper_ff[TIMER_SLOTS-1];
      qtsk_up[TIMER_SLOTS-1] = qtsk_ff[TIMER_SLOTS-1];
      for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
         exp_up[i]  = exp_ff[i+1];
         per_up[i]  = per_ff[i+1];
         tsk_up[i]  = tsk_ff[i+1];
         qper_up[i] = qper_ff[i+1];
         qtsk_up[i] = qtsk_ff[i+1];
      end
   end

   // Table update: sorted insert or removal of the head.
   always_comb begin
      pend_in = pend_ff;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         exp_in[i] = exp_ff[i];
         per_in[i] = per_ff[i];
         tsk_in[i] = tsk_ff[i];
         if (ins_en) begin
            if (gt_prev[i]) begin
               exp_in[i] = exp_dn[i];
               per_in[i] = per_dn[i];
               tsk_in[i] = tsk_dn[i];
            end else if (gt[i] || (CW'(i) == pend_ff)) begin
               exp_in[i] = ins_exp;
               per_in[i] = ins_per;
               tsk_in[i] = ins_tid;
            end
         end else if (cmd.pop_head) begin
            exp_in[i] = exp_up[i];
            per_in[i] = per_up[i];
            tsk_in[i] = tsk_up[i];
         end
      end
      if (ins_en) begin
         pend_in = pend_ff + 1'b1;
      end else if (cmd.pop_head) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   // Fired queue update: append, rotate for reinsertion, or drain.
   always_comb begin
      fcnt_in = fcnt_ff;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         qper_in[i] = qper_ff[i];
         qtsk_in[i] = qtsk_ff[i];
         if (cmd.pop_head) begin
            if (CW'(i) == fcnt_ff) begin
               qper_in[i] = per_ff[0];
               qtsk_in[i] = tsk_ff[0];
            end
         end else if (cmd.reins) begin
            if (CW'(i + 1) == fcnt_ff) begin
               qper_in[i] = qper_ff[0];
               qtsk_in[i] = qtsk_ff[0];
            end else begin
               qper_in[i] = qper_up[i];
               qtsk_in[i] = qtsk_up[i];
            end
         end else if (cmd.emit && fired_kind) begin
            qper_in[i] = qper_up[i];
            qtsk_in[i] = qtsk_up[i];
         end
      end
      if (cmd.load) begin
         fcnt_in = '0;
      end else if (cmd.pop_head) begin
         fcnt_in = fcnt_ff + 1'b1;
      end else if (cmd.emit && fired_kind) begin
         fcnt_in = fcnt_ff - 1'b1;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      per_ff  <= per_in;
      tsk_ff  <= tsk_in;
      qper_ff <= qper_in;
      qtsk_ff <= qtsk_in;
      if (cmd.load) begin
         now_ff   <= req_data[47:0];
         delay_ff <= req_data[79:48];
         ival_ff  <= req_data[111:80];
         tid_ff   <= req_data[119:112];
      end
      if (cmd.calc) begin
         if (pend_ff == '0) begin
            near_ff <= EXP_W'(idle_ff);
         end else if (head_due) begin
            near_ff <= '0;
         end else begin
            near_ff <= exp_ff[0] - {1'b0, now_ff};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         fcnt_ff  <= '0;
         rcnt_ff  <= '0;
         kind_ff  <= KIND_INFO;
         acc_ff   <= 1'b0;
         early_ff <= 1'b0;
         idle_ff  <= IDLE_TIMEOUT_RST;
      end else begin
         pend_ff <= pend_in;
         fcnt_ff <= fcnt_in;
         if (csr_we) begin
            idle_ff <= csr_wdata;
         end
         if (cmd.load) begin
            rcnt_ff  <= '0;
            acc_ff   <= 1'b0;
            early_ff <= 1'b0;
            case (req_user)
               REQ_ADD:    kind_ff <= KIND_ACK;
               REQ_EXPIRE: kind_ff <= KIND_FIRED;
               default:    kind_ff <= KIND_INFO;
            endcase
         end else begin
            if (cmd.reins) begin
               rcnt_ff <= rcnt_ff + 1'b1;
            end
            if (cmd.set_none) begin
               kind_ff <= KIND_INFO;
            end
            if (cmd.add) begin
               acc_ff   <= ins_en;
               early_ff <= ins_en && ((pend_ff == '0) || gt[0]);
            end
         end
      end
   end

   // Status and result fields.
   assign stat.head_due   = head_due;
   assign stat.fire_empty = (fcnt_ff == '0);
   assign stat.reins_last = (CW'(rcnt_ff + 1'b1) == fcnt_ff);
   assign stat.out_last   = !fired_kind || (fcnt_ff == CW'(1));

   assign rsp_user = kind_ff;
   assign rsp_data = {5'b0, near_ff, early_ff, acc_ff,
                      fired_kind ? qtsk_ff[0] : TASK_W'(0)};

endmodule

@@ hdl/stq_ctrl.sv @@
module stq_ctrl
   import stq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_user,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_FIRE,
      S_REINS,
      S_CALC,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      rdy_ff;
   logic      vld_ff;

   assign req_ready = rdy_ff;
   assign rsp_valid = vld_ff;

   // Commands decoded from the current state.
   always_comb begin
      cmd          = '0;
      cmd.load     = req_valid && rdy_ff;
      cmd.add      = (state_ff == S_ADD);
      cmd.pop_head = (state_ff == S_FIRE) && stat.head_due;
      cmd.set_none = (state_ff == S_FIRE) && !stat.head_due && stat.fire_empty;
      cmd.reins    = (state_ff == S_REINS);
      cmd.calc     = (state_ff == S_CALC);
      cmd.emit     = (state_ff == S_EMIT) && vld_ff && rsp_ready;
   end

   // Sequencer with its registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rdy_ff   <= 1'b1;
         vld_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && rdy_ff) begin
                  rdy_ff <= 1'b0;
                  case (req_user)
                     REQ_ADD:    state_ff <= S_ADD;
                     REQ_EXPIRE: state_ff <= S_FIRE;
                     default:    state_ff <= S_CALC;
                  endcase
               end
            end
            S_ADD: begin
               state_ff <= S_CALC;
            end
            S_FIRE: begin
               if (!stat.head_due) begin
                  state_ff <= stat.fire_empty ? S_CALC : S_REINS;
               end
            end
            S_REINS: begin
               if (stat.reins_last) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               state_ff <= S_EMIT;
               vld_ff   <= 1'b1;
            end
            S_EMIT: begin
               if (rsp_ready && stat.out_last) begin
                  state_ff <= S_IDLE;
                  vld_ff   <= 1'b0;
                  rdy_ff   <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               rdy_ff   <= 1'b1;
               vld_ff   <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ hdl/stq_checker.sv @@
`include "sorted_timer_queue_defines.svh"

module stq_checker
   import stq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser,
   input logic              rsp_tlast
);

   // No new request is taken while a result item is on offer.
   `STQ_ASSERT_IMPL(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready)

   // A result never appears in the cycle right after a request is taken.
   `STQ_ASSERT_NEXT(a_no_instant_result, clock, reset, req_tvalid && req_tready, !rsp_tvalid)

   // Only fired-timer results can be followed by more items of the same request.
   `STQ_ASSERT_IMPL(a_single_last, clock, reset, rsp_tvalid && (rsp_tuser != KIND_FIRED), rsp_tlast)

   // A stalled result item stays offered and unchanged.
   `STQ_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
